>>> rtl/core/assert_macros.svh
// assertion helpers shared by the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while in reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// implication checked on every rising clock edge, off while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

>>> rtl/core/pidaw_pkg.sv
`timescale 1ns / 1ps

package pidaw_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_W      = DATA_W - 1;
    localparam int LIM_W     = DATA_W - 1;
    localparam int MUL_W     = 2 * DATA_W - FRAC_BITS;
    localparam int MUL_CNT_W = $clog2(DATA_W);
    localparam int DIV_A_W   = DATA_W + 1;
    localparam int DIV_NUM_W = DIV_A_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
    localparam int SUM_W     = DATA_W + 2;
    localparam int REG_NUM   = 4;
    localparam int ADDR_W    = $clog2(REG_NUM) + 2;
    localparam int APB_W     = 32;

    typedef enum logic [$clog2(REG_NUM)-1:0] {
        REG_GAIN_P      = 2'd0,
        REG_GAIN_I      = 2'd1,
        REG_GAIN_D      = 2'd2,
        REG_DRIVE_LIMIT = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_RATE,
        ST_EDT,
        ST_INTEG,
        ST_TERM,
        ST_CLAMP,
        ST_PMUL,
        ST_IMUL,
        ST_DMUL,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    localparam logic signed [MUL_W-1:0] MUL_HI = MUL_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [MUL_W-1:0] MUL_LO = -MUL_HI - MUL_W'(1);
    localparam logic signed [DATA_W-1:0] D_HI  = DATA_W'(MUL_HI);
    localparam logic signed [DATA_W-1:0] D_LO  = DATA_W'(MUL_LO);

    // saturate a product to the data range
    function automatic logic signed [DATA_W-1:0] sat_mul(input logic signed [MUL_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > MUL_HI)
            r = D_HI;
        else if (x < MUL_LO)
            r = D_LO;
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

    // saturate a one-bit-grown sum to the data range
    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W:0] x);
        logic signed [DATA_W-1:0] r;
        if (x[DATA_W] != x[DATA_W-1])
            r = x[DATA_W] ? D_LO : D_HI;
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/core/pidaw_if.sv
`timescale 1ns / 1ps

interface pidaw_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   command;
    logic signed [pidaw_pkg::DATA_W-1:0]    measured;
    logic signed [pidaw_pkg::DATA_W-1:0]    target;
    logic        [pidaw_pkg::DT_W-1:0]      step_time;

    modport source (output valid, command, measured, target, step_time, input ready);
    modport sink (input valid, command, measured, target, step_time, output ready);
endinterface

interface pidaw_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pidaw_pkg::DATA_W-1:0]    drive;
    logic signed [pidaw_pkg::DATA_W-1:0]    error_now;
    logic signed [pidaw_pkg::DATA_W-1:0]    rate_of_error;
    logic signed [pidaw_pkg::DATA_W-1:0]    integral_now;

    modport source (output valid, drive, error_now, rate_of_error, integral_now, input ready);
    modport sink (input valid, drive, error_now, rate_of_error, integral_now, output ready);
endinterface

>>> rtl/core/pid_controller_antiwindup_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// pid controller with integral clamp, signed q16.16
//
// in_ch carries update words (command, measured, target, step_time); a word
// with command set clears the integral and the previous error and gives no
// result. every other word gives one result word on out_ch: drive, error,
// rate of error and the clamped integral.
// gains and the drive limit are written through the apb port (byte address
// 4*index); they must be written only while the block is idle, which the
// block itself does not enforce; pready is always high.
// each update word runs through a serial divide for the rate, a serial
// multiply for error*dt, a multiply for the anti-windup check when the
// integral gain is nonzero plus a divide when the integral is clamped, then
// three multiplies for the drive terms. one word is in work at a time;
// in_ch.ready is high only while the sequencer is idle, so a new update word
// is taken only after the last result is loaded; a clear word is taken
// without leaving the idle state.
// the result sits in an output register; if out_ch stalls, the sequencer
// waits in its last state and the state is updated when the result is loaded.
// reset clears the gains, limit, integral, previous error and output valid.
module pid_controller_antiwindup_top (
    input  logic                                clk,
    input  logic                                rst_n,
    pidaw_in_if.sink                            in_ch,
    pidaw_out_if.source                         out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pidaw_pkg::ADDR_W-1:0]        paddr,
    input  logic [pidaw_pkg::APB_W-1:0]         pwdata,
    output logic [pidaw_pkg::APB_W-1:0]         prdata,
    output logic                                pready
);

    localparam int DW = pidaw_pkg::DATA_W;
    localparam int AW = pidaw_pkg::DIV_A_W;
    localparam int SW = pidaw_pkg::SUM_W;

    // configuration registers
    logic signed [DW-1:0]                   gain_p_reg;
    logic signed [DW-1:0]                   gain_i_reg;
    logic signed [DW-1:0]                   gain_d_reg;
    logic [pidaw_pkg::LIM_W-1:0]            limit_reg;
    pidaw_pkg::reg_idx_t                    reg_idx;
    logic                                   cfg_wr;

    // controller state and working registers
    pidaw_pkg::state_t                      state_reg;
    pidaw_pkg::state_t                      state_next;
    logic signed [DW-1:0]                   integ_reg;
    logic signed [DW-1:0]                   last_err_reg;
    logic signed [DW-1:0]                   meas_reg;
    logic signed [DW-1:0]                   goal_reg;
    logic [pidaw_pkg::DT_W-1:0]             dt_reg;
    logic signed [DW-1:0]                   err_reg;
    logic signed [DW-1:0]                   rate_reg;
    logic signed [DW-1:0]                   inew_reg;
    logic signed [SW-1:0]                   sum_reg;

    // output register
    logic                                   out_valid_reg;
    logic signed [DW-1:0]                   drive_reg;
    logic signed [DW-1:0]                   oerr_reg;
    logic signed [DW-1:0]                   orate_reg;
    logic signed [DW-1:0]                   ointeg_reg;

    // arithmetic units
    logic                                   mul_start;
    logic signed [DW-1:0]                   mul_a;
    logic signed [DW-1:0]                   mul_b;
    pidaw_pkg::unit_stat_t                  mul_stat;
    logic signed [pidaw_pkg::MUL_W-1:0]     mul_res;
    logic                                   div_start;
    logic signed [AW-1:0]                   div_a;
    logic signed [AW-1:0]                   div_b;
    pidaw_pkg::unit_stat_t                  div_stat;
    logic signed [DW-1:0]                   div_res;

    // datapath helpers
    logic signed [DW-1:0]                   err_c;
    logic signed [DW-1:0]                   edt_sat;
    logic signed [DW-1:0]                   integ_c;
    logic signed [pidaw_pkg::MUL_W-1:0]     lim_w;
    logic signed [SW-1:0]                   lim_s;
    logic signed [SW-1:0]                   sum_add;
    logic signed [DW-1:0]                   drive_c;
    logic                                   in_acc;
    logic                                   out_load;

    assign in_acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == pidaw_pkg::ST_IDLE);

    // apb register file
    assign pready  = 1'b1;
    assign reg_idx = pidaw_pkg::reg_idx_t'(paddr[pidaw_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            limit_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                pidaw_pkg::REG_GAIN_P:      gain_p_reg <= pwdata[DW-1:0];
                pidaw_pkg::REG_GAIN_I:      gain_i_reg <= pwdata[DW-1:0];
                pidaw_pkg::REG_GAIN_D:      gain_d_reg <= pwdata[DW-1:0];
                pidaw_pkg::REG_DRIVE_LIMIT: limit_reg  <= pwdata[pidaw_pkg::LIM_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pidaw_pkg::REG_GAIN_P:      prdata = gain_p_reg;
            pidaw_pkg::REG_GAIN_I:      prdata = gain_i_reg;
            pidaw_pkg::REG_GAIN_D:      prdata = gain_d_reg;
            pidaw_pkg::REG_DRIVE_LIMIT: prdata = {1'b0, limit_reg};
            default:                    prdata = '0;
        endcase
    end

    // serial units
    pidaw_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .stat   (mul_stat),
        .result (mul_res)
    );

    pidaw_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .a      (div_a),
        .b      (div_b),
        .stat   (div_stat),
        .result (div_res)
    );

    // error and integral candidates
    assign err_c   = pidaw_pkg::sat_add({goal_reg[DW-1], goal_reg} - {meas_reg[DW-1], meas_reg});
    assign edt_sat = pidaw_pkg::sat_mul(mul_res);
    assign integ_c = pidaw_pkg::sat_add({integ_reg[DW-1], integ_reg}
                                        + {edt_sat[DW-1], edt_sat});
    assign lim_w   = signed'({{(pidaw_pkg::MUL_W - pidaw_pkg::LIM_W){1'b0}}, limit_reg});
    assign lim_s   = signed'({{(SW - pidaw_pkg::LIM_W){1'b0}}, limit_reg});
    // each drive term saturates before it joins the sum
    assign sum_add = sum_reg + SW'(pidaw_pkg::sat_mul(mul_res));

    // final drive clamp against the limit
    always_comb
    begin
        if (sum_reg > lim_s)
            drive_c = DW'(lim_s);
        else if (sum_reg < -lim_s)
            drive_c = DW'(-lim_s);
        else
            drive_c = sum_reg[DW-1:0];
    end

    assign out_load = (state_reg == pidaw_pkg::ST_FINAL) && !out_valid_reg;

    // sequencer: next state and unit launches
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = err_reg;
        mul_b      = signed'({1'b0, dt_reg});
        div_start  = 1'b0;
        div_a      = {err_c[DW-1], err_c} - {last_err_reg[DW-1], last_err_reg};
        div_b      = signed'({2'b00, dt_reg});
        case (state_reg)
            pidaw_pkg::ST_IDLE:
            begin
                if (in_acc && !in_ch.command)
                    state_next = pidaw_pkg::ST_ERR;
            end
            pidaw_pkg::ST_ERR:
            begin
                div_start  = 1'b1;
                state_next = pidaw_pkg::ST_RATE;
            end
            pidaw_pkg::ST_RATE:
            begin
                if (div_stat.done)
                begin
                    mul_start  = 1'b1;
                    state_next = pidaw_pkg::ST_EDT;
                end
            end
            pidaw_pkg::ST_EDT:
            begin
                if (mul_stat.done)
                    state_next = pidaw_pkg::ST_INTEG;
            end
            pidaw_pkg::ST_INTEG:
            begin
                mul_start = 1'b1;
                if (gain_i_reg != '0)
                begin
                    mul_a      = gain_i_reg;
                    mul_b      = inew_reg;
                    state_next = pidaw_pkg::ST_TERM;
                end
                else
                begin
                    mul_a      = gain_p_reg;
                    mul_b      = err_reg;
                    state_next = pidaw_pkg::ST_PMUL;
                end
            end
            pidaw_pkg::ST_TERM:
            begin
                if (mul_stat.done)
                begin
                    div_b = {gain_i_reg[DW-1], gain_i_reg};
                    if (mul_res > lim_w)
                    begin
                        div_start  = 1'b1;
                        div_a      = AW'(lim_s);
                        state_next = pidaw_pkg::ST_CLAMP;
                    end
                    else if (mul_res < -lim_w)
                    begin
                        div_start  = 1'b1;
                        div_a      = AW'(-lim_s);
                        state_next = pidaw_pkg::ST_CLAMP;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a      = gain_p_reg;
                        mul_b      = err_reg;
                        state_next = pidaw_pkg::ST_PMUL;
                    end
                end
            end
            pidaw_pkg::ST_CLAMP:
            begin
                if (div_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = gain_p_reg;
                    mul_b      = err_reg;
                    state_next = pidaw_pkg::ST_PMUL;
                end
            end
            pidaw_pkg::ST_PMUL:
            begin
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = gain_i_reg;
                    mul_b      = inew_reg;
                    state_next = pidaw_pkg::ST_IMUL;
                end
            end
            pidaw_pkg::ST_IMUL:
            begin
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = gain_d_reg;
                    mul_b      = rate_reg;
                    state_next = pidaw_pkg::ST_DMUL;
                end
            end
            pidaw_pkg::ST_DMUL:
            begin
                if (mul_stat.done)
                    state_next = pidaw_pkg::ST_FINAL;
            end
            pidaw_pkg::ST_FINAL:
            begin
                if (out_load)
                    state_next = pidaw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pidaw_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pidaw_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            last_err_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            // clear command wipes the controller memory
            if (in_acc && in_ch.command)
            begin
                integ_reg    <= '0;
                last_err_reg <= '0;
            end
            else if (out_load)
            begin
                integ_reg    <= inew_reg;
                last_err_reg <= err_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            meas_reg <= in_ch.measured;
            goal_reg <= in_ch.target;
            dt_reg   <= in_ch.step_time;
        end
        if (state_reg == pidaw_pkg::ST_ERR)
            err_reg <= err_c;
        if (state_reg == pidaw_pkg::ST_RATE && div_stat.done)
            rate_reg <= div_res;
        if (state_reg == pidaw_pkg::ST_EDT && mul_stat.done)
            inew_reg <= integ_c;
        if (state_reg == pidaw_pkg::ST_CLAMP && div_stat.done)
            inew_reg <= div_res;
        if (state_reg == pidaw_pkg::ST_PMUL && mul_stat.done)
            sum_reg <= SW'(pidaw_pkg::sat_mul(mul_res));
        if ((state_reg == pidaw_pkg::ST_IMUL || state_reg == pidaw_pkg::ST_DMUL)
            && mul_stat.done)
            sum_reg <= sum_add;
        if (out_load)
        begin
            drive_reg  <= drive_c;
            oerr_reg   <= err_reg;
            orate_reg  <= rate_reg;
            ointeg_reg <= inew_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.drive         = drive_reg;
    assign out_ch.error_now     = oerr_reg;
    assign out_ch.rate_of_error = orate_reg;
    assign out_ch.integral_now  = ointeg_reg;

    `ASSERT_IMPL(mul_start_when_free, clk, rst_n, mul_start, !mul_stat.busy)
    `ASSERT_IMPL(div_start_when_free, clk, rst_n, div_start, !div_stat.busy)
    `ASSERT_IMPL(units_never_overlap, clk, rst_n, mul_stat.busy, !div_stat.busy)

endmodule

>>> rtl/core/pidaw_mul.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// bit-serial shift-add multiplier, (a*b) >> frac truncated toward zero
module pidaw_mul (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [pidaw_pkg::DATA_W-1:0]     a,
    input  logic signed [pidaw_pkg::DATA_W-1:0]     b,
    output pidaw_pkg::unit_stat_t                   stat,
    output logic signed [pidaw_pkg::MUL_W-1:0]      result
);

    localparam int DW = pidaw_pkg::DATA_W;

    logic [DW-1:0]                      amag_reg;
    logic [2*DW-1:0]                    prod_reg;
    logic [2*DW-1:0]                    prod_next;
    logic [pidaw_pkg::MUL_CNT_W-1:0]    cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;
    logic                               neg_reg;
    logic [DW-1:0]                      amag;
    logic [DW-1:0]                      bmag;
    logic [DW:0]                        psum;
    logic [pidaw_pkg::MUL_W-1:0]        mmag;

    assign amag = a[DW-1] ? (~a + DW'(1)) : a;
    assign bmag = b[DW-1] ? (~b + DW'(1)) : b;

    assign psum      = {1'b0, prod_reg[2*DW-1:DW]} + (prod_reg[0] ? {1'b0, amag_reg} : '0);
    assign prod_next = {psum, prod_reg[DW-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pidaw_pkg::MUL_CNT_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            amag_reg <= amag;
            prod_reg <= {{DW{1'b0}}, bmag};
            neg_reg  <= a[DW-1] ^ b[DW-1];
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign mmag        = prod_reg[2*DW-1:pidaw_pkg::FRAC_BITS];
    assign result      = neg_reg ? -signed'(mmag) : signed'(mmag);
    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;

    `ASSERT_CLK(mul_done_on_finish, clk, rst_n, $fell(busy_reg) |-> done_reg)

endmodule

>>> rtl/core/pidaw_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// restoring divider, one quotient bit a cycle: (a << frac) / b, saturated
module pidaw_div (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [pidaw_pkg::DIV_A_W-1:0]    a,
    input  logic signed [pidaw_pkg::DIV_A_W-1:0]    b,
    output pidaw_pkg::unit_stat_t                   stat,
    output logic signed [pidaw_pkg::DATA_W-1:0]     result
);

    localparam int DW = pidaw_pkg::DATA_W;
    localparam int AW = pidaw_pkg::DIV_A_W;
    localparam int NW = pidaw_pkg::DIV_NUM_W;
    localparam logic [NW-1:0] Q_LIM = NW'(1) << (DW - 1);

    logic [NW-1:0]                      nq_reg;
    logic [DW-1:0]                      rem_reg;
    logic [DW-1:0]                      den_reg;
    logic [pidaw_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;
    logic                               neg_reg;
    logic                               a_neg_reg;
    logic                               a_zero_reg;
    logic                               den_zero_reg;
    logic [AW-1:0]                      amag;
    logic [AW-1:0]                      bmag;
    logic [DW+1:0]                      trial;
    logic                               qbit;

    assign amag  = a[AW-1] ? (~a + AW'(1)) : a;
    assign bmag  = b[AW-1] ? (~b + AW'(1)) : b;
    assign trial = {1'b0, rem_reg, nq_reg[NW-1]} - {2'b00, den_reg};
    assign qbit  = !trial[DW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pidaw_pkg::DIV_CNT_W'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg       <= {amag, {pidaw_pkg::FRAC_BITS{1'b0}}};
            rem_reg      <= '0;
            den_reg      <= bmag[DW-1:0];
            neg_reg      <= a[AW-1] ^ b[AW-1];
            a_neg_reg    <= a[AW-1];
            a_zero_reg   <= (a == '0);
            den_zero_reg <= (b == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? trial[DW-1:0] : {rem_reg[DW-2:0], nq_reg[NW-1]};
            nq_reg  <= {nq_reg[NW-2:0], qbit};
        end
    end

    always_comb
    begin
        if (den_zero_reg)
            result = a_zero_reg ? '0 : (a_neg_reg ? pidaw_pkg::D_LO : pidaw_pkg::D_HI);
        else if (neg_reg)
            result = (nq_reg >= Q_LIM) ? pidaw_pkg::D_LO : -signed'(nq_reg[DW-1:0]);
        else
            result = (nq_reg >= Q_LIM) ? pidaw_pkg::D_HI : signed'(nq_reg[DW-1:0]);
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `ASSERT_CLK(div_done_on_finish, clk, rst_n, $fell(busy_reg) |-> done_reg)

endmodule

>>> verif/pid_controller_antiwindup_top_tb.sv
`timescale 1ns / 1ps

module pid_controller_antiwindup_top_tb;

    // one expected output word
    typedef struct {
        logic signed [pidaw_pkg::DATA_W-1:0] drive;
        logic signed [pidaw_pkg::DATA_W-1:0] error_now;
        logic signed [pidaw_pkg::DATA_W-1:0] rate_of_error;
        logic signed [pidaw_pkg::DATA_W-1:0] integral_now;
    } pid_word_t;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;
    localparam int DRAIN_CYCLES = 400;
    localparam int DT_W = pidaw_pkg::DT_W;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [pidaw_pkg::ADDR_W-1:0] paddr;
    logic [pidaw_pkg::APB_W-1:0] pwdata;
    logic [pidaw_pkg::APB_W-1:0] prdata;
    logic pready;

    pidaw_in_if in_ch ();
    pidaw_out_if out_ch ();

    pid_controller_antiwindup_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the gain registers and the controller state
    longint gain_p_q;
    longint gain_i_q;
    longint gain_d_q;
    longint limit_q;
    longint integral_q;
    longint last_err_q;

    pid_word_t expected_words[$];
    int error_count;
    int stall_mode = 0;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // saturate to the signed data range
    function automatic longint sat_q(input longint x);
        if (x > Q_HI)
            return Q_HI;
        if (x < Q_LO)
            return Q_LO;
        return x;
    endfunction

    // fixed point product, truncated toward zero
    function automatic longint mul_q(input longint a, input longint b);
        bit [63:0] ma;
        bit [63:0] mb;
        bit [63:0] m;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        m = (ma * mb) >> pidaw_pkg::FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    // fixed point quotient, truncated toward zero and saturated
    function automatic longint div_q(input longint a, input longint b);
        bit [63:0] num;
        bit [63:0] den;
        bit [63:0] q;
        if (b == 0)
        begin
            // zero step time: saturate toward the sign of the numerator
            if (a == 0)
                return 0;
            return (a < 0) ? Q_LO : Q_HI;
        end
        num = ((a < 0) ? 64'(-a) : 64'(a)) << pidaw_pkg::FRAC_BITS;
        den = (b < 0) ? 64'(-b) : 64'(b);
        q = num / den;
        if (q > 64'd2147483648)
            q = 64'd2147483648;
        return sat_q(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q));
    endfunction

    // controller step for one update word; moves the shadow state
    function automatic pid_word_t pid_update(input longint meas, input longint goal,
                                             input longint dt);
        pid_word_t w;
        longint err;
        longint rate;
        longint integ;
        longint term;
        longint u;
        err = sat_q(goal - meas);
        rate = div_q(err - last_err_q, dt);
        integ = sat_q(integral_q + sat_q(mul_q(err, dt)));
        // anti-windup clamp, skipped with zero integral gain
        if (gain_i_q != 0)
        begin
            term = mul_q(gain_i_q, integ);
            if (term > limit_q)
                integ = div_q(limit_q, gain_i_q);
            else if (term < -limit_q)
                integ = div_q(-limit_q, gain_i_q);
        end
        u = sat_q(mul_q(gain_p_q, err)) + sat_q(mul_q(gain_i_q, integ))
            + sat_q(mul_q(gain_d_q, rate));
        if (u > limit_q)
            u = limit_q;
        else if (u < -limit_q)
            u = -limit_q;
        u = sat_q(u);
        integral_q = integ;
        last_err_q = err;
        w.drive = u[pidaw_pkg::DATA_W-1:0];
        w.error_now = err[pidaw_pkg::DATA_W-1:0];
        w.rate_of_error = rate[pidaw_pkg::DATA_W-1:0];
        w.integral_now = integ[pidaw_pkg::DATA_W-1:0];
        return w;
    endfunction

    // apb write: setup cycle then access cycle
    task automatic write_reg(input pidaw_pkg::reg_idx_t idx,
                             input logic [pidaw_pkg::APB_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= pidaw_pkg::ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pidaw_pkg::REG_GAIN_P: gain_p_q = longint'($signed(value));
            pidaw_pkg::REG_GAIN_I: gain_i_q = longint'($signed(value));
            pidaw_pkg::REG_GAIN_D: gain_d_q = longint'($signed(value));
            pidaw_pkg::REG_DRIVE_LIMIT: limit_q = longint'(value[pidaw_pkg::LIM_W-1:0]);
            default: ;
        endcase
    endtask

    // wait until every result is in, then let a trailing clear settle
    task automatic drain_results();
        int waited;
        waited = 0;
        while (expected_words.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_words.size() != 0)
        begin
            $error("results still pending after drain: %0d", expected_words.size());
            error_count++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_gains(input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] kd, input logic [31:0] lim);
        // the last word must not be taken again while the gains change
        in_ch.valid <= 1'b0;
        drain_results();
        write_reg(pidaw_pkg::REG_GAIN_P, kp);
        write_reg(pidaw_pkg::REG_GAIN_I, ki);
        write_reg(pidaw_pkg::REG_GAIN_D, kd);
        write_reg(pidaw_pkg::REG_DRIVE_LIMIT, lim);
    endtask

    // present one word and hold it until taken; valid stays high afterwards
    task automatic send_word(input logic cmd, input logic [31:0] meas,
                             input logic [31:0] goal, input logic [DT_W-1:0] dt);
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.measured <= meas;
        in_ch.target <= goal;
        in_ch.step_time <= dt;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (cmd)
        begin
            integral_q = 0;
            last_err_q = 0;
        end
        else
            expected_words.push_back(pid_update(longint'($signed(meas)),
                                                longint'($signed(goal)),
                                                longint'(dt)));
    endtask

    task automatic idle_sender(input int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // value with a spread of magnitudes
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 2 << 18)) - (1 << 18));
            1: return 32'($signed($urandom_range(0, 2 << 24)) - (1 << 24));
            2: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] rand_step();
        case ($urandom_range(0, 9))
            0: return DT_W'($urandom);
            1: return DT_W'($urandom_range(0, 3));
            2: return DT_W'($urandom_range(1 << 16, 1 << 22));
            default: return DT_W'($urandom_range(1, 1 << 17));
        endcase
    endfunction

    task automatic test_reset_defaults();
        // all registers zero after reset: drive stays zero, integral free
        send_word(1'b0, 32'h0001_0000, 32'h0003_0000, DT_W'(32'h0001_0000));
        send_word(1'b0, 32'hffff_0000, 32'h0002_8000, DT_W'(32'h0000_8000));
        idle_sender(3);
    endtask

    task automatic test_directed();
        set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0010_0000);
        // extremes of the inputs and full range error
        send_word(1'b0, 32'h8000_0000, 32'h7fff_ffff, DT_W'(1));
        send_word(1'b0, 32'h7fff_ffff, 32'h8000_0000, DT_W'(1));
        send_word(1'b0, 32'h0000_0000, 32'h0000_0000, {DT_W{1'b1}});
        send_word(1'b0, 32'h0001_0000, 32'h7fff_ffff, {DT_W{1'b1}});
        // zero step time, with two negative error changes and then none
        send_word(1'b0, 32'h0000_0000, 32'h0002_0000, DT_W'(0));
        send_word(1'b0, 32'h0000_0000, 32'hfffe_0000, DT_W'(0));
        send_word(1'b0, 32'h0000_0000, 32'hfffe_0000, DT_W'(0));
        // clear, then an update from clean state
        send_word(1'b1, 32'h1234_5678, 32'h8765_4321, DT_W'(5));
        send_word(1'b0, 32'h0000_1000, 32'h0005_0000, DT_W'(32'h0001_0000));
        send_word(1'b1, 32'h0, 32'h0, DT_W'(0));
        idle_sender(2);
        // zero integral gain: no clamp
        set_gains(32'h0002_0000, 32'h0000_0000, 32'hffff_0000, 32'h7fff_ffff);
        repeat (4) send_word(1'b0, 32'h0, 32'h7000_0000, DT_W'(32'h0004_0000));
        idle_sender(1);
        // zero drive limit: drive zero and integral clamped to zero
        set_gains(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0);
        send_word(1'b0, 32'h0, 32'h0003_0000, DT_W'(32'h0001_0000));
        send_word(1'b0, 32'h0005_0000, 32'h0, DT_W'(32'h0002_0000));
        // extreme gains
        set_gains(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(1'b0, 32'h0, 32'h0000_0100, DT_W'(32'h0001_0000));
        send_word(1'b0, 32'h0000_0100, 32'h0, DT_W'(1));
        send_word(1'b0, 32'hc000_0000, 32'h4000_0000, {DT_W{1'b1}});
        idle_sender(1);
    endtask

    // random words in bursts, under one gain setting
    task automatic run_random(input int count);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 16);
                // some bursts start with no gap at all
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 20));
            end
            burst--;
            if ($urandom_range(0, 19) == 0)
                send_word(1'b1, $urandom, $urandom, DT_W'($urandom));
            else if ($urandom_range(0, 49) == 0)
                send_word(1'b0, rand_value(), rand_value(), DT_W'(0));
            else
                send_word(1'b0, rand_value(), rand_value(), rand_step());
        end
        idle_sender(1);
    endtask

    task automatic test_random();
        set_gains(32'h0001_8000, 32'h0000_4000, 32'h0000_2000, 32'h0040_0000);
        run_random(120);
        set_gains($urandom, $urandom, $urandom, $urandom);
        run_random(100);
        set_gains(32'h0000_0100, 32'h0, 32'h0000_0100, 32'h7fff_ffff);
        run_random(80);
        set_gains(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        run_random(60);
        set_gains($urandom, $urandom & 32'h0003_ffff, $urandom, $urandom_range(0, 1 << 20));
        run_random(140);
    endtask

    // receiver ready pattern; mode changes every so often
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 1) != 0);
            2: out_ch.ready <= ($urandom_range(0, 7) == 0);
            default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        pid_word_t w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                w = expected_words.pop_front();
                if (out_ch.drive !== w.drive)
                begin
                    $error("drive expected %0d actual %0d", w.drive, out_ch.drive);
                    error_count++;
                end
                if (out_ch.error_now !== w.error_now)
                begin
                    $error("error_now expected %0d actual %0d", w.error_now,
                           out_ch.error_now);
                    error_count++;
                end
                if (out_ch.rate_of_error !== w.rate_of_error)
                begin
                    $error("rate_of_error expected %0d actual %0d", w.rate_of_error,
                           out_ch.rate_of_error);
                    error_count++;
                end
                if (out_ch.integral_now !== w.integral_now)
                begin
                    $error("integral_now expected %0d actual %0d", w.integral_now,
                           out_ch.integral_now);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        error_count = 0;
        gain_p_q = 0;
        gain_i_q = 0;
        gain_d_q = 0;
        limit_q = 0;
        integral_q = 0;
        last_err_q = 0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.command <= 1'b0;
        in_ch.measured <= '0;
        in_ch.target <= '0;
        in_ch.step_time <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_random();
        drain_results();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #40ms;
        $display("Verification failed");
        $finish;
    end

endmodule
